### hw/rtl/kvt_pkg.sv
// Shared types and codes for the key/value table.
package kvt_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CAPACITY_DEF = 16;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_SEARCH = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DUP      = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e_t;

  typedef struct packed {
    logic              active;
    logic              hit;
    logic              free_seen;
    logic [DATA_W-1:0] value;
  } kvt_chain_t;

  typedef struct packed {
    logic              en;
    logic              ins;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
  } kvt_cmd_t;

endpackage

### hw/rtl/kvt_cell.sv
// One table entry: compares the passing request token and applies commit commands.
module kvt_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [kvt_pkg::DATA_W-1:0]    req_key,
  input  kvt_pkg::kvt_cmd_t             cmd,
  input  kvt_pkg::kvt_chain_t           chain_in,
  output kvt_pkg::kvt_chain_t           chain_out
);
  import kvt_pkg::*;

  logic              valid_r, valid_nxt;
  logic [DATA_W-1:0] key_r, key_nxt;
  logic [DATA_W-1:0] value_r, value_nxt;
  logic              match_r, match_nxt;
  logic              first_free_r, first_free_nxt;
  kvt_chain_t        chain_r, chain_nxt;
  logic              my_match;

  assign my_match  = valid_r && (key_r == req_key);
  assign chain_out = chain_r;

  always_comb begin
    valid_nxt      = valid_r;
    key_nxt        = key_r;
    value_nxt      = value_r;
    match_nxt      = match_r;
    first_free_nxt = first_free_r;
    chain_nxt      = chain_in;
    if (chain_in.active) begin
      match_nxt           = my_match;
      first_free_nxt      = !valid_r && !chain_in.free_seen;
      chain_nxt.hit       = chain_in.hit || my_match;
      chain_nxt.free_seen = chain_in.free_seen || !valid_r;
      if (my_match) begin
        chain_nxt.value = value_r;
      end
    end
    if (cmd.en) begin
      if (cmd.ins) begin
        if (first_free_r) begin
          valid_nxt = 1'b1;
          key_nxt   = cmd.key;
          value_nxt = cmd.value;
        end
      end else if (match_r) begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      match_r      <= 1'b0;
      first_free_r <= 1'b0;
      chain_r      <= '0;
    end else begin
      valid_r      <= valid_nxt;
      match_r      <= match_nxt;
      first_free_r <= first_free_nxt;
      chain_r      <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

endmodule

### hw/rtl/key_value_table_unit.sv
// Top level of the key/value table: request control, cell row and result register.
//
// A table of up to CAPACITY unique signed keys with one value each. A request
// (insert, search or remove) is taken on start while busy is low. It travels
// down the row of CAPACITY entry cells, one cell per cycle, gathering the
// match and the lowest free entry; the table update is then broadcast to the
// cells. One result is shown on out_strobe for a single cycle once the request
// has left the last cell, and busy is already low in that cycle, so a new request
// can be taken then, but none is taken while an earlier one is still in the row.
// The receiver cannot stall; results must be taken when out_strobe is high.
module key_value_table_unit #(
  parameter int unsigned CAPACITY = kvt_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_func,
  input  logic signed [kvt_pkg::DATA_W-1:0] in_key,
  input  logic signed [kvt_pkg::DATA_W-1:0] in_value,
  output logic                              out_strobe,
  output logic [1:0]                        out_status,
  output logic signed [kvt_pkg::DATA_W-1:0] out_found_value
);
  import kvt_pkg::*;

  logic              busy_r, busy_nxt;
  logic              launch_r, launch_nxt;
  func_e_t           func_r, func_nxt;
  logic [DATA_W-1:0] key_r, key_nxt;
  logic [DATA_W-1:0] value_r, value_nxt;
  logic              strobe_r, strobe_nxt;
  status_e_t         status_r, status_nxt;
  logic [DATA_W-1:0] found_r, found_nxt;
  kvt_cmd_t          cmd_r, cmd_nxt;
  kvt_chain_t        chain [0:CAPACITY];
  kvt_chain_t        tail;
  logic              accept;

  assign accept = start && !busy_r;
  assign tail   = chain[CAPACITY];

  assign chain[0] = '{active: launch_r, default: '0};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    kvt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .req_key   (key_r),
      .cmd       (cmd_r),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1])
    );
  end

  always_comb begin
    busy_nxt   = busy_r;
    launch_nxt = accept;
    func_nxt   = func_r;
    key_nxt    = key_r;
    value_nxt  = value_r;
    strobe_nxt = 1'b0;
    status_nxt = status_r;
    found_nxt  = found_r;
    cmd_nxt    = cmd_r;
    cmd_nxt.en = 1'b0;
    if (accept) begin
      busy_nxt  = 1'b1;
      func_nxt  = func_e_t'(in_func);
      key_nxt   = in_key;
      value_nxt = in_value;
    end
    if (tail.active) begin
      busy_nxt      = 1'b0;
      strobe_nxt    = 1'b1;
      status_nxt    = ST_OK;
      found_nxt     = '0;
      cmd_nxt.key   = key_r;
      cmd_nxt.value = value_r;
      cmd_nxt.ins   = 1'b0;
      case (func_r)
        FUNC_INSERT: begin
          cmd_nxt.ins = 1'b1;
          if (tail.hit) begin
            status_nxt = ST_DUP;
          end else if (tail.free_seen) begin
            cmd_nxt.en = 1'b1;
          end else begin
            status_nxt = ST_FULL;
          end
        end
        FUNC_SEARCH: begin
          if (tail.hit) begin
            found_nxt = tail.value;
          end else begin
            status_nxt = ST_NOTFOUND;
          end
        end
        FUNC_REMOVE: begin
          if (tail.hit) begin
            cmd_nxt.en = 1'b1;
          end else begin
            status_nxt = ST_NOTFOUND;
          end
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      launch_r <= 1'b0;
      strobe_r <= 1'b0;
      cmd_r    <= '0;
    end else begin
      busy_r   <= busy_nxt;
      launch_r <= launch_nxt;
      strobe_r <= strobe_nxt;
      cmd_r    <= cmd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r   <= func_nxt;
    key_r    <= key_nxt;
    value_r  <= value_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
  end

  assign busy            = busy_r;
  assign out_strobe      = strobe_r;
  assign out_status      = status_r;
  assign out_found_value = found_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r)
    else $error("busy not raised after request transfer");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> !busy_r && !launch_r)
    else $error("result shown while a request is in flight");

  a_cmd_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_r.en |-> strobe_r && (status_r == ST_OK))
    else $error("table update without a successful result");

  a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r && (status_r != ST_OK) |-> (found_r == '0))
    else $error("nonzero value on a failed request");

endmodule

### test/tb_top.sv
// Self-checking testbench for the key/value table: directed and random insert, search and remove.
`timescale 1ns / 100ps

module tb_top;
  import kvt_pkg::*;

  localparam int unsigned TBL_DEPTH  = CAPACITY_DEF;
  localparam int unsigned POOL_DEPTH = 40;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef logic signed [DATA_W-1:0] kv_word_t;

  typedef struct {
    status_e_t status;
    kv_word_t  value;
  } lookup_result_t;

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [1:0]                in_func = FUNC_NONE;
  logic signed [DATA_W-1:0]  in_key = '0;
  logic signed [DATA_W-1:0]  in_value = '0;
  logic                      out_strobe;
  logic [1:0]                out_status;
  logic signed [DATA_W-1:0]  out_found_value;

  kv_word_t       table_keys [TBL_DEPTH];
  kv_word_t       table_values [TBL_DEPTH];
  bit             table_used [TBL_DEPTH];
  kv_word_t       key_pool [POOL_DEPTH];
  lookup_result_t pending_results [$];
  int unsigned    error_count = 0;
  int unsigned    idle_cycles = 0;
  bit             idle_on = 1'b1;

  key_value_table_unit #(
    .CAPACITY(TBL_DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_func(in_func),
    .in_key(in_key),
    .in_value(in_value),
    .out_strobe(out_strobe),
    .out_status(out_status),
    .out_found_value(out_found_value)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void apply_request(input func_e_t f, input kv_word_t k, input kv_word_t v,
                                        output lookup_result_t r);
    int hit_idx;
    int free_idx;
    hit_idx = -1;
    free_idx = -1;
    for (int i = TBL_DEPTH - 1; i >= 0; i--) begin
      if (table_used[i] && table_keys[i] == k) hit_idx = i;
      if (!table_used[i]) free_idx = i;
    end
    r.status = ST_OK;
    r.value = '0;
    case (f)
      FUNC_INSERT: begin
        if (hit_idx >= 0) r.status = ST_DUP;
        else if (free_idx < 0) r.status = ST_FULL;
        else begin
          table_keys[free_idx] = k;
          table_values[free_idx] = v;
          table_used[free_idx] = 1'b1;
        end
      end
      FUNC_SEARCH: begin
        if (hit_idx >= 0) r.value = table_values[hit_idx];
        else r.status = ST_NOTFOUND;
      end
      FUNC_REMOVE: begin
        if (hit_idx >= 0) table_used[hit_idx] = 1'b0;
        else r.status = ST_NOTFOUND;
      end
      default: ;
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 85) return $urandom_range(3, 1);
    if (p < 95) return $urandom_range(12, 4);
    return $urandom_range(40, 20);
  endfunction

  task automatic send_request(input func_e_t f, input kv_word_t k, input kv_word_t v);
    lookup_result_t r;
    int unsigned gap;
    start <= 1'b1;
    in_func <= f;
    in_key <= k;
    in_value <= v;
    do @(posedge clk); while (busy);
    apply_request(f, k, v, r);
    pending_results.push_back(r);
    gap = idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic test_directed();
    idle_on = 1'b1;
    send_request(FUNC_SEARCH, key_pool[0], '0);
    send_request(FUNC_INSERT, key_pool[0], 32'sh7fffffff);
    send_request(FUNC_INSERT, key_pool[1], 32'sh80000000);
    send_request(FUNC_INSERT, key_pool[0], 32'sh5a5a5a5a);
    send_request(FUNC_SEARCH, key_pool[0], 32'shffffffff);
    send_request(FUNC_REMOVE, key_pool[1], '0);
    send_request(FUNC_REMOVE, key_pool[1], '0);
    send_request(FUNC_SEARCH, key_pool[1], '0);
    send_request(FUNC_NONE, key_pool[0], 32'sh12345678);
    for (int i = 2; i < 17; i++) send_request(FUNC_INSERT, key_pool[i], kv_word_t'($urandom));
    send_request(FUNC_INSERT, key_pool[17], kv_word_t'($urandom));
    send_request(FUNC_INSERT, key_pool[0], kv_word_t'($urandom));
  endtask

  task automatic test_random_mix(input int unsigned pool_size, input int unsigned count,
                                 input bit with_idle);
    func_e_t     f;
    kv_word_t    k;
    int unsigned p;
    idle_on = with_idle;
    for (int n = 0; n < count; n++) begin
      p = $urandom_range(99);
      if (p < 40) f = FUNC_INSERT;
      else if (p < 70) f = FUNC_SEARCH;
      else if (p < 95) f = FUNC_REMOVE;
      else f = FUNC_NONE;
      if ($urandom_range(99) < 85) k = key_pool[$urandom_range(pool_size - 1)];
      else k = kv_word_t'($urandom);
      send_request(f, k, kv_word_t'($urandom));
    end
  endtask

  always @(posedge clk) begin
    lookup_result_t r;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d value %0d",
                 $time, out_status, out_found_value);
        error_count++;
      end else begin
        r = pending_results.pop_front();
        if (out_status !== r.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, r.status, out_status);
          error_count++;
        end
        if (out_found_value !== r.value) begin
          $display("%0t: found_value mismatch: expected %0d, actual %0d",
                   $time, r.value, out_found_value);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    key_pool[0] = 32'sh80000000;
    key_pool[1] = 32'sh7fffffff;
    key_pool[2] = '0;
    key_pool[3] = -1;
    for (int i = 4; i < POOL_DEPTH; i++) key_pool[i] = kv_word_t'($urandom);
    for (int i = 0; i < TBL_DEPTH; i++) table_used[i] = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_directed();
    test_random_mix(8, 600, 1'b0);
    test_random_mix(24, 700, 1'b1);
    test_random_mix(POOL_DEPTH, 600, 1'b1);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TBL_DEPTH + 6) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/kvt_pkg.sv
hw/rtl/kvt_cell.sv
hw/rtl/key_value_table_unit.sv
test/tb_top.sv
